### hdl/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int ADDR_W   = 40;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int BYTES_W  = 28;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 2'd2;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST   = 40'd2147483648;
  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 40'd2147483648;
  localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 40'd2281701376;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_FREE   = 3'd2,
    OP_INCREF = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_OOM       = 3'd1,
    STAT_BAD_ADDR  = 3'd2,
    STAT_COUNT_ERR = 3'd3,
    STAT_COUNT_OVF = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ALLOC_CHK,
    S_INIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic push_en;
    logic exec;
    logic alloc_chk;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_init;
    logic alloc_pending;
    logic sweep_last;
  } dp_status_t;

  // unused codes behave as query
  function automatic op_t decode_op(input logic [OP_W-1:0] code);
    op_t res;
    unique case (code)
      3'd0:    res = OP_INIT;
      3'd1:    res = OP_ALLOC;
      3'd2:    res = OP_FREE;
      3'd3:    res = OP_INCREF;
      default: res = OP_QUERY;
    endcase
    return res;
  endfunction

endpackage

### hdl/rpa_ctrl.sv
`timescale 1ns / 1ps

module rpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rpa_pkg::dp_status_t dp_status,
  output rpa_pkg::ctrl_cmd_t  cmd,
  output logic               busy
);

  import rpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (dp_status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = dp_status.in_init ? S_INIT : S_EXEC;
      end
      S_EXEC: begin
        state_next = dp_status.alloc_pending ? S_ALLOC_CHK : S_IDLE;
      end
      S_ALLOC_CHK: begin
        state_next = S_IDLE;
      end
      S_INIT: begin
        if (dp_status.sweep_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != S_IDLE);
    cmd.accept    = (state == S_IDLE) && start;
    cmd.sweep     = (state == S_CLEAR) || (state == S_INIT);
    cmd.push_en   = (state == S_INIT);
    cmd.exec      = (state == S_EXEC);
    cmd.alloc_chk = (state == S_ALLOC_CHK);
    cmd.emit      = ((state == S_EXEC) && !dp_status.alloc_pending) ||
                    (state == S_ALLOC_CHK) ||
                    ((state == S_INIT) && dp_status.sweep_last);
  end

endmodule

### hdl/rpa_datapath.sv
`timescale 1ns / 1ps

module rpa_datapath #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rpa_pkg::ctrl_cmd_t               cmd,
  output rpa_pkg::dp_status_t              dp_status,
  input  logic                             cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpa_pkg::ADDR_W-1:0]       cfg_data,
  input  logic [rpa_pkg::OP_W-1:0]         op,
  input  logic [rpa_pkg::ADDR_W-1:0]       page_address,
  output logic                             done,
  output logic [rpa_pkg::ADDR_W-1:0]       alloc_address,
  output logic [rpa_pkg::STATUS_W-1:0]     status,
  output logic                             page_released,
  output logic [rpa_pkg::BYTES_W-1:0]      free_bytes
);

  import rpa_pkg::*;

  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int TOP_W      = $clog2(NUM_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int KFULL_W    = ADDR_W - PAGE_SHIFT;
  localparam int SPAN_W     = ADDR_W + 1;
  localparam int PROD_W     = TOP_W + PAGE_SHIFT;
  localparam int WIDE_W     = (PROD_W > BYTES_W) ? PROD_W : BYTES_W;

  logic [ADDR_W-1:0] ram_base;
  logic [ADDR_W-1:0] kernel_end;
  logic [ADDR_W-1:0] phys_top;

  logic [COUNT_W-1:0] counts [NUM_PAGES];
  logic [IDX_W-1:0]   stack  [NUM_PAGES];

  logic [TOP_W-1:0]  free_top;
  logic [TOP_W-1:0]  free_top_next;
  logic [IDX_W-1:0]  sweep_k;
  logic [SPAN_W-1:0] page_start;

  op_t                op_q;
  logic [IDX_W-1:0]   page_q;
  logic               bad_free_q;
  logic               bad_inc_q;
  logic [COUNT_W-1:0] count_rd;
  logic [IDX_W-1:0]   stack_rd;

  // address decode of the incoming beat
  logic               in_range;
  logic [ADDR_W-1:0]  addr_off;
  logic [KFULL_W-1:0] k_full;
  logic               k_ok;
  logic               aligned;
  logic               bad_inc;
  logic               bad_free;
  logic [IDX_W-1:0]   acc_idx;

  logic [IDX_W-1:0]   top_m1;
  logic [IDX_W-1:0]   count_ra;
  logic [SPAN_W-1:0]  page_end;
  logic               qualify;

  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wa;
  logic [IDX_W-1:0]   stk_wd;

  logic [ADDR_W-1:0]  res_addr;
  status_t            res_status;
  logic               res_rel;
  logic [WIDE_W-1:0]  bytes_wide;
  logic [BYTES_W-1:0] bytes_sat;

  always_comb begin
    in_range = (page_address >= ram_base) && (page_address < phys_top);
    addr_off = page_address - ram_base;
    k_full   = addr_off[ADDR_W-1:PAGE_SHIFT];
    k_ok     = k_full < KFULL_W'(NUM_PAGES);
    aligned  = (addr_off[PAGE_SHIFT-1:0] == '0);
    bad_inc  = !(in_range && k_ok);
    bad_free = bad_inc || (page_address < kernel_end) || !aligned;
    acc_idx  = bad_inc ? '0 : k_full[IDX_W-1:0];
  end

  assign top_m1   = IDX_W'(free_top - TOP_W'(1));
  assign count_ra = cmd.exec ? stack_rd : acc_idx;

  // a page goes on the stack when it lies wholly between kernel end and top
  assign page_end = page_start + SPAN_W'(PAGE_BYTES);
  assign qualify  = (page_start >= {1'b0, kernel_end}) && (page_end <= {1'b0, phys_top});

  assign dp_status.in_init       = (decode_op(op) == OP_INIT);
  assign dp_status.alloc_pending = (op_q == OP_ALLOC) && (free_top != '0);
  assign dp_status.sweep_last    = (sweep_k == IDX_W'(NUM_PAGES - 1));

  always_comb begin
    free_top_next = free_top;
    cnt_we        = 1'b0;
    cnt_wa        = page_q;
    cnt_wd        = '0;
    stk_we        = 1'b0;
    stk_wa        = IDX_W'(free_top);
    stk_wd        = page_q;
    res_addr      = '0;
    res_status    = STAT_OK;
    res_rel       = 1'b0;
    if (cmd.sweep) begin
      cnt_we = 1'b1;
      cnt_wa = sweep_k;
      cnt_wd = '0;
      if (cmd.push_en && qualify) begin
        stk_we        = 1'b1;
        stk_wd        = sweep_k;
        free_top_next = free_top + TOP_W'(1);
      end
    end else if (cmd.exec) begin
      unique case (op_q)
        OP_ALLOC: begin
          if (free_top == '0) begin
            res_status = STAT_OOM;
          end else begin
            free_top_next = free_top - TOP_W'(1);
          end
        end
        OP_FREE: begin
          if (bad_free_q) begin
            res_status = STAT_BAD_ADDR;
          end else if (count_rd == '0) begin
            res_status = STAT_COUNT_ERR;
          end else begin
            cnt_we = 1'b1;
            cnt_wd = count_rd - COUNT_W'(1);
            // last reference gone: back onto the stack unless it is full
            if ((count_rd == COUNT_W'(1)) && (free_top < TOP_W'(NUM_PAGES))) begin
              stk_we        = 1'b1;
              free_top_next = free_top + TOP_W'(1);
              res_rel       = 1'b1;
            end
          end
        end
        OP_INCREF: begin
          if (bad_inc_q) begin
            res_status = STAT_BAD_ADDR;
          end else if (count_rd == '0) begin
            res_status = STAT_COUNT_ERR;
          end else if (count_rd == COUNT_MAX) begin
            res_status = STAT_COUNT_OVF;
          end else begin
            cnt_we = 1'b1;
            cnt_wd = count_rd + COUNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.alloc_chk) begin
      // page already popped; a live count means it cannot be handed out
      if (count_rd != '0) begin
        res_status = STAT_COUNT_ERR;
      end else begin
        cnt_we   = 1'b1;
        cnt_wa   = stack_rd;
        cnt_wd   = COUNT_W'(1);
        res_addr = ram_base + (ADDR_W'(stack_rd) << PAGE_SHIFT);
      end
    end
  end

  always_comb begin
    bytes_wide = WIDE_W'(free_top_next) << PAGE_SHIFT;
    bytes_sat  = (bytes_wide > WIDE_W'(BYTES_MAX)) ? BYTES_MAX : bytes_wide[BYTES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base   <= RAM_BASE_RST;
      kernel_end <= KERNEL_END_RST;
      phys_top   <= PHYS_TOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_BASE:   ram_base   <= cfg_data;
        CFG_KERNEL_END: kernel_end <= cfg_data;
        CFG_PHYS_TOP:   phys_top   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
      sweep_k  <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.accept && dp_status.in_init) begin
        free_top <= '0;
        sweep_k  <= '0;
      end else begin
        free_top <= free_top_next;
        if (cmd.sweep) begin
          sweep_k <= dp_status.sweep_last ? '0 : sweep_k + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= decode_op(op);
      page_q     <= acc_idx;
      bad_free_q <= bad_free;
      bad_inc_q  <= bad_inc;
      page_start <= {1'b0, ram_base};
    end else if (cmd.sweep) begin
      page_start <= page_end;
    end
    if (cmd.emit) begin
      alloc_address <= res_addr;
      status        <= res_status;
      page_released <= res_rel;
      free_bytes    <= bytes_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts[cnt_wa] <= cnt_wd;
    end
    if (cmd.accept || cmd.exec) begin
      count_rd <= counts[count_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_wa] <= stk_wd;
    end
    if (cmd.accept && (free_top != '0)) begin
      stack_rd <= stack[top_m1];
    end
  end

endmodule

### hdl/refcounted_page_allocator.sv
`timescale 1ns / 1ps

// page allocator with a lifo free stack and an 8-bit reference count per page
// command channel: a beat (op, page_address) is taken on a clock edge with
// start high and busy low; busy stays high until the result is out
// result channel: done is high for exactly one cycle with alloc_address,
// status, page_released and free_bytes; the receiver cannot stall it
// configuration: cfg_we, cfg_index, cfg_data write a register at once;
// write only while the block is idle
// sequence from accept to done: query, free, incref and empty alloc run
// through the execute state; alloc adds an allocation check (stack read at
// accept, then count read of the popped page); init sweeps every page once
// through the count memory write port
// at most one command is in flight; a new beat is taken only while busy is low
// reset: config registers take their reset values and a clearing pass
// zeroes all counts with busy high; the stack is empty
// PAGE_BYTES must be a power of two

module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rpa_pkg::OP_W-1:0]      op,
  input  logic [rpa_pkg::ADDR_W-1:0]    page_address,
  output logic                          done,
  output logic [rpa_pkg::ADDR_W-1:0]    alloc_address,
  output logic [rpa_pkg::STATUS_W-1:0]  status,
  output logic                          page_released,
  output logic [rpa_pkg::BYTES_W-1:0]   free_bytes,
  input  logic                          cfg_we,
  input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpa_pkg::ADDR_W-1:0]    cfg_data
);

  import rpa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy)
  );

  rpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .page_address  (page_address),
    .done          (done),
    .alloc_address (alloc_address),
    .status        (status),
    .page_released (page_released),
    .free_bytes    (free_bytes)
  );

endmodule
